@@ rtl/wgma_pkg.sv @@
// Shared types, constants and arithmetic helpers for the weighted gram accumulator.
`timescale 1ns / 1ps

package wgma_pkg;

  localparam int VAL_W   = 16;
  localparam int WT_W    = 16;
  localparam int SEL_W   = 3;
  localparam int IDX_W   = 8;
  localparam int FC_W    = 5;
  localparam int ACC_W   = 64;
  localparam int XW_W    = 33;  // value * weight, signed
  localparam int OPB_W   = 17;  // second multiplier operand, signed
  localparam int PROD_W  = XW_W + OPB_W;

  localparam logic [FC_W-1:0] FC_RESET = 5'd16;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_FEATURE = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [SEL_W-1:0] {
    SEL_GRAM = 3'd0,
    SEL_XY   = 3'd1,
    SEL_X    = 3'd2,
    SEL_WT   = 3'd3,
    SEL_TS   = 3'd4,
    SEL_TSQ  = 3'd5
  } sel_e;

  // Kind of one accumulate element travelling down the MAC pipe
  typedef enum logic [2:0] {
    K_GRAM = 3'd0,
    K_XY   = 3'd1,
    K_XS   = 3'd2,
    K_TS   = 3'd3,
    K_TSQ  = 3'd4
  } kind_e;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_XW    = 6'b000100,
    ST_ISSUE = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_READ  = 6'b100000
  } state_e;

  typedef struct packed {
    logic load_begin;
    logic load_feat;
    logic load_read;
    logic clear_all;
    logic clr_step;
    logic xw_step;
    logic issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic feat_ok;
    logic issue_last;
    logic pipe_busy;
    logic clr_last;
    logic ovf;
  } status_t;

  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic             ovf;
  } sat_t;

  function automatic sat_t sat_add(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
    sat_t             r;
    logic [ACC_W-1:0] s;
    s     = a + b;
    r.sum = s;
    r.ovf = 1'b0;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      r.ovf = 1'b1;
      r.sum = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return r;
  endfunction

endpackage

@@ rtl/wgma_if.sv @@
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface wgma_in_if;
  logic                                 valid;
  logic                                 ready;
  wgma_pkg::op_e                        op;
  logic signed [wgma_pkg::VAL_W-1:0]    value;
  logic [wgma_pkg::WT_W-1:0]            weight;
  logic [wgma_pkg::SEL_W-1:0]           read_select;
  logic [wgma_pkg::IDX_W-1:0]           read_index;

  modport source (output valid, op, value, weight, read_select, read_index, input ready);
  modport sink (input valid, op, value, weight, read_select, read_index, output ready);
endinterface

interface wgma_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wgma_pkg::ACC_W-1:0]    read_value;
  logic                                 saturated;

  modport source (output valid, read_value, saturated, input ready);
  modport sink (input valid, read_value, saturated, output ready);
endinterface

@@ rtl/wgma_ctrl.sv @@
// Sequencing state machine: item acceptance, MAC issue, drain, clear sweep, read out.
`timescale 1ns / 1ps

module wgma_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  wgma_pkg::op_e     in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wgma_pkg::status_t status_i,
  output wgma_pkg::cmd_t    cmd_o
);

  wgma_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      wgma_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = wgma_pkg::ST_IDLE;
        end
      end
      wgma_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_op_i)
            wgma_pkg::OP_BEGIN: begin
              cmd_o.load_begin = 1'b1;
              state_d          = wgma_pkg::ST_XW;
            end
            wgma_pkg::OP_FEATURE: begin
              // features past the active count are dropped, but the first of a sample is always taken
              if (status_i.feat_ok) begin
                cmd_o.load_feat = 1'b1;
                state_d         = wgma_pkg::ST_XW;
              end
            end
            wgma_pkg::OP_READ: begin
              cmd_o.load_read = 1'b1;
              state_d         = wgma_pkg::ST_READ;
            end
            wgma_pkg::OP_CLEAR: begin
              cmd_o.clear_all = 1'b1;
              state_d         = wgma_pkg::ST_CLEAR;
            end
            default: state_d = wgma_pkg::ST_IDLE;
          endcase
        end
      end
      wgma_pkg::ST_XW: begin
        cmd_o.xw_step = 1'b1;
        state_d       = wgma_pkg::ST_ISSUE;
      end
      wgma_pkg::ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (status_i.issue_last) begin
          state_d = wgma_pkg::ST_DRAIN;
        end
      end
      wgma_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = wgma_pkg::ST_IDLE;
        end
      end
      wgma_pkg::ST_READ: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = wgma_pkg::ST_IDLE;
        end
      end
      default: state_d = wgma_pkg::ST_CLEAR;
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wgma_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/wgma_datapath.sv @@
// Accumulator stores, shared multiplier, three-stage MAC pipe, clear sweep and read mux.
`timescale 1ns / 1ps

module wgma_datapath #(
  parameter int MAX_FEATURES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wgma_pkg::FC_W-1:0]            cfg_wdata_i,
  input  logic signed [wgma_pkg::VAL_W-1:0]    value_i,
  input  logic [wgma_pkg::WT_W-1:0]            weight_i,
  input  logic [wgma_pkg::SEL_W-1:0]           read_select_i,
  input  logic [wgma_pkg::IDX_W-1:0]           read_index_i,
  input  wgma_pkg::cmd_t                       cmd_i,
  output wgma_pkg::status_t                    status_o,
  output logic signed [wgma_pkg::ACC_W-1:0]    read_value_o,
  output logic                                 saturated_o
);

  localparam int GD = MAX_FEATURES * (MAX_FEATURES + 1) / 2;
  localparam int GA = (GD > 1) ? $clog2(GD) : 1;
  localparam int FA = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int PW = $clog2(MAX_FEATURES + 1);
  localparam int AW = wgma_pkg::ACC_W;

  // configuration and per-sample registers
  logic [wgma_pkg::FC_W-1:0]          fc_q;
  logic signed [wgma_pkg::VAL_W-1:0]  val_q;
  logic [wgma_pkg::WT_W-1:0]          sample_w_q;
  logic signed [wgma_pkg::VAL_W-1:0]  sample_t_q;
  logic [PW-1:0]                      pos_q;
  logic [GA-1:0]                      base_q;
  logic                               begin_q;
  logic signed [wgma_pkg::XW_W-1:0]   xw_q;

  // scalar sums and sticky flag
  logic [AW-1:0] wt_q, ts_q, tsq_q;
  logic          ovf_q;

  // issue side
  wgma_pkg::kind_e kind_q;
  logic [FA-1:0]   j_q;
  logic [GA-1:0]   clr_cnt_q;

  // pipe stages
  logic                                 v1_q, v2_q;
  wgma_pkg::kind_e                      k1_q, k2_q;
  logic [GA-1:0]                        a1_q, a2_q;
  logic signed [wgma_pkg::PROD_W-1:0]   prod_q;
  logic [AW-1:0]                        acc_q;

  // memories and their read registers
  logic [AW-1:0]                      gram_mem [GD];
  logic [AW-1:0]                      xs_mem   [MAX_FEATURES];
  logic [AW-1:0]                      xys_mem  [MAX_FEATURES];
  logic signed [wgma_pkg::VAL_W-1:0]  feat_mem [MAX_FEATURES];
  logic [AW-1:0]                      gram_rd_q, xs_rd_q, xys_rd_q;
  logic signed [wgma_pkg::VAL_W-1:0]  feat_rd_q;

  // read item registers
  logic [GA-1:0]              rd_gaddr_q;
  logic [FA-1:0]              rd_faddr_q;
  logic [wgma_pkg::SEL_W-1:0] rd_sel_q;
  logic                       rd_oob_q, rd_oob_d;
  logic [AW-1:0]              out_val_q;
  logic                       out_sat_q;

  logic [GA-1:0]                      gram_ra, gram_addr_iss;
  logic [FA-1:0]                      fx_ra;
  logic signed [wgma_pkg::XW_W-1:0]   mul_a;
  logic signed [wgma_pkg::OPB_W-1:0]  mul_b, opb;
  logic signed [wgma_pkg::PROD_W-1:0] mul_p;
  logic [AW-1:0]                      acc_sel, rd_val;
  wgma_pkg::sat_t                     mac_sum, wt_sum;
  logic                               iss_last, clr_last, clr_fx;

  // ---------------- status ----------------
  assign iss_last = (kind_q == wgma_pkg::K_XS) || (kind_q == wgma_pkg::K_TSQ);
  assign clr_last = (clr_cnt_q == GA'(GD - 1));
  assign clr_fx   = (32'(clr_cnt_q) < 32'(MAX_FEATURES));

  always_comb begin
    status_o.feat_ok    = (32'(pos_q) < 32'(MAX_FEATURES)) &&
                          ((32'(pos_q) < 32'(fc_q)) || (pos_q == '0));
    status_o.issue_last = iss_last;
    status_o.pipe_busy  = v1_q | v2_q;
    status_o.clr_last   = clr_last;
    status_o.ovf        = ovf_q;
  end

  // ---------------- addresses ----------------
  assign gram_addr_iss = base_q + GA'(j_q);

  always_comb begin
    if (cmd_i.issue) begin
      gram_ra = gram_addr_iss;
      fx_ra   = pos_q[FA-1:0];
    end else if (cmd_i.load_read) begin
      gram_ra = GA'(read_index_i);
      fx_ra   = FA'(read_index_i);
    end else begin
      gram_ra = rd_gaddr_q;
      fx_ra   = rd_faddr_q;
    end
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    unique case (k1_q)
      wgma_pkg::K_GRAM:                 opb = wgma_pkg::OPB_W'(feat_rd_q);
      wgma_pkg::K_XY, wgma_pkg::K_TSQ:  opb = wgma_pkg::OPB_W'(sample_t_q);
      default:                          opb = wgma_pkg::OPB_W'(1);
    endcase
  end

  always_comb begin
    if (cmd_i.xw_step) begin
      mul_a = wgma_pkg::XW_W'(val_q);
      mul_b = signed'({1'b0, sample_w_q});
    end else begin
      mul_a = xw_q;
      mul_b = opb;
    end
    mul_p = wgma_pkg::PROD_W'(mul_a) * wgma_pkg::PROD_W'(mul_b);
  end

  always_comb begin
    unique case (k1_q)
      wgma_pkg::K_GRAM: acc_sel = gram_rd_q;
      wgma_pkg::K_XY:   acc_sel = xys_rd_q;
      wgma_pkg::K_XS:   acc_sel = xs_rd_q;
      wgma_pkg::K_TS:   acc_sel = ts_q;
      default:          acc_sel = tsq_q;
    endcase
  end

  assign mac_sum = wgma_pkg::sat_add(acc_q, AW'(prod_q));
  assign wt_sum  = wgma_pkg::sat_add(wt_q, AW'(sample_w_q));

  // ---------------- read-out mux ----------------
  always_comb begin
    unique case (rd_sel_q)
      wgma_pkg::SEL_GRAM: rd_val = gram_rd_q;
      wgma_pkg::SEL_XY:   rd_val = xys_rd_q;
      wgma_pkg::SEL_X:    rd_val = xs_rd_q;
      wgma_pkg::SEL_WT:   rd_val = wt_q;
      wgma_pkg::SEL_TS:   rd_val = ts_q;
      wgma_pkg::SEL_TSQ:  rd_val = tsq_q;
      default:            rd_val = '0;
    endcase
    if (rd_oob_q) begin
      rd_val = '0;
    end
  end

  always_comb begin
    unique case (read_select_i)
      wgma_pkg::SEL_GRAM:           rd_oob_d = !(32'(read_index_i) < 32'(GD));
      wgma_pkg::SEL_XY,
      wgma_pkg::SEL_X:              rd_oob_d = !(32'(read_index_i) < 32'(MAX_FEATURES));
      wgma_pkg::SEL_WT,
      wgma_pkg::SEL_TS,
      wgma_pkg::SEL_TSQ:            rd_oob_d = 1'b0;
      default:                      rd_oob_d = 1'b1;
    endcase
  end

  assign read_value_o = out_val_q;
  assign saturated_o  = out_sat_q;

  // ---------------- control and scalar state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q       <= wgma_pkg::FC_RESET;
      sample_w_q <= '0;
      sample_t_q <= '0;
      pos_q      <= '0;
      base_q     <= '0;
      begin_q    <= 1'b0;
      wt_q       <= '0;
      ts_q       <= '0;
      tsq_q      <= '0;
      ovf_q      <= 1'b0;
      kind_q     <= wgma_pkg::K_GRAM;
      j_q        <= '0;
      clr_cnt_q  <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fc_q <= cfg_wdata_i;
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;

      if (cmd_i.clear_all) begin
        sample_w_q <= '0;
        sample_t_q <= '0;
        pos_q      <= '0;
        base_q     <= '0;
        wt_q       <= '0;
        ts_q       <= '0;
        tsq_q      <= '0;
        ovf_q      <= 1'b0;
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_last ? '0 : clr_cnt_q + GA'(1);
      end

      if (cmd_i.load_begin) begin
        sample_w_q <= weight_i;
        sample_t_q <= value_i;
        pos_q      <= '0;
        base_q     <= '0;
        begin_q    <= 1'b1;
        kind_q     <= wgma_pkg::K_TS;
      end
      if (cmd_i.load_feat) begin
        begin_q <= 1'b0;
        kind_q  <= wgma_pkg::K_GRAM;
        j_q     <= '0;
      end

      if (cmd_i.xw_step && begin_q) begin
        wt_q <= wt_sum.sum;
        if (wt_sum.ovf) begin
          ovf_q <= 1'b1;
        end
      end

      if (cmd_i.issue) begin
        unique case (kind_q)
          wgma_pkg::K_GRAM: begin
            if (j_q == pos_q[FA-1:0]) begin
              kind_q <= wgma_pkg::K_XY;
            end else begin
              j_q <= j_q + FA'(1);
            end
          end
          wgma_pkg::K_XY: kind_q <= wgma_pkg::K_XS;
          wgma_pkg::K_XS: begin
            // row done: advance to the next feature position
            pos_q  <= pos_q + PW'(1);
            base_q <= base_q + GA'(pos_q) + GA'(1);
          end
          wgma_pkg::K_TS: kind_q <= wgma_pkg::K_TSQ;
          default:        kind_q <= wgma_pkg::K_TSQ;
        endcase
      end

      if (v2_q) begin
        if (mac_sum.ovf) begin
          ovf_q <= 1'b1;
        end
        if (k2_q == wgma_pkg::K_TS) begin
          ts_q <= mac_sum.sum;
        end
        if (k2_q == wgma_pkg::K_TSQ) begin
          tsq_q <= mac_sum.sum;
        end
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_begin || cmd_i.load_feat) begin
      val_q <= value_i;
    end
    if (cmd_i.xw_step) begin
      xw_q <= mul_p[wgma_pkg::XW_W-1:0];
    end
    k1_q   <= kind_q;
    a1_q   <= (kind_q == wgma_pkg::K_GRAM) ? gram_addr_iss : GA'(pos_q[FA-1:0]);
    k2_q   <= k1_q;
    a2_q   <= a1_q;
    prod_q <= mul_p;
    acc_q  <= acc_sel;
    if (cmd_i.load_read) begin
      rd_gaddr_q <= GA'(read_index_i);
      rd_faddr_q <= FA'(read_index_i);
      rd_sel_q   <= read_select_i;
      rd_oob_q   <= rd_oob_d;
    end
    if (cmd_i.out_load) begin
      out_val_q <= rd_val;
      out_sat_q <= ovf_q;
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      gram_mem[clr_cnt_q] <= '0;
    end else if (v2_q && (k2_q == wgma_pkg::K_GRAM)) begin
      gram_mem[a2_q] <= mac_sum.sum;
    end
    gram_rd_q <= gram_mem[gram_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && clr_fx) begin
      xs_mem[clr_cnt_q[FA-1:0]] <= '0;
    end else if (v2_q && (k2_q == wgma_pkg::K_XS)) begin
      xs_mem[a2_q[FA-1:0]] <= mac_sum.sum;
    end
    xs_rd_q <= xs_mem[fx_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && clr_fx) begin
      xys_mem[clr_cnt_q[FA-1:0]] <= '0;
    end else if (v2_q && (k2_q == wgma_pkg::K_XY)) begin
      xys_mem[a2_q[FA-1:0]] <= mac_sum.sum;
    end
    xys_rd_q <= xys_mem[fx_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.xw_step && !begin_q) begin
      feat_mem[pos_q[FA-1:0]] <= val_q;
    end
    feat_rd_q <= feat_mem[j_q];
  end

endmodule

@@ rtl/weighted_gram_matrix_accumulator_core.sv @@
// States: begin and taken feature items pass XW, ISSUE, DRAIN; read items pass READ.
// Throughput: one item at a time; the feature row update streams p+3 MAC elements through
//   one shared 33x17 multiplier and a three-stage read/multiply/accumulate pipe.
// Reset: async active low; after reset, and after every clear item, a sweep zeroes the
//   accumulator memories at one entry per cycle (MAX_FEATURES*(MAX_FEATURES+1)/2 entries,
//   136 by default) while no item is accepted; config writes are taken at any time.
`timescale 1ns / 1ps

module weighted_gram_matrix_accumulator_core #(
  parameter int MAX_FEATURES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wgma_pkg::FC_W-1:0] cfg_wdata_i,
  wgma_in_if.sink                   in_i,
  wgma_out_if.source                out_o
);

  // Control/datapath split: the controller only sequences, all storage
  // and arithmetic live in the datapath.
  wgma_pkg::cmd_t    dp_cmd;
  wgma_pkg::status_t dp_status;

  wgma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  // Datapath: gram triangle, xy and x sums live in RAMs; scalar sums in flops.
  // Each feature item streams row p (p+1 gram entries) then xy and x sums.
  wgma_datapath #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .value_i       (in_i.value),
    .weight_i      (in_i.weight),
    .read_select_i (in_i.read_select),
    .read_index_i  (in_i.read_index),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .read_value_o  (out_o.read_value),
    .saturated_o   (out_o.saturated)
  );

  // No item is taken while MAC writes are still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !dp_status.pipe_busy)
    else $error("item accepted with MAC pipe busy");

  // A clear item starts the sweep and drops the saturation flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.op == wgma_pkg::OP_CLEAR)
      |=> (!in_i.ready && !dp_status.ovf))
    else $error("clear did not start sweep or keep flag low");

  // Saturation is sticky until a clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_status.ovf && !(in_i.valid && in_i.ready && in_i.op == wgma_pkg::OP_CLEAR))
      |=> dp_status.ovf)
    else $error("saturation flag dropped without clear");

endmodule
